// ===== hw/rtl/sfd_pkg.sv =====
// Shared types and constants for the serial command frame decoder.
// Depends on nothing; every other file of the block but sfd_if imports it.
`default_nettype none

package sfd_pkg;

    // Frame bytes
    localparam logic [7:0] PREAMBLE = 8'hAA;
    localparam logic [7:0] ACK_BYTE = 8'h00;
    localparam logic [7:0] ERR_BYTE = 8'h01;

    // Command codes
    localparam logic [7:0] CMD_CHANNEL      = 8'h00;
    localparam logic [7:0] CMD_RUN_CYCLES   = 8'h01;
    localparam logic [7:0] CMD_MASK_TABLE   = 8'h02;
    localparam logic [7:0] CMD_PRE_DELAY    = 8'h03;
    localparam logic [7:0] CMD_POST_DELAY   = 8'h04;
    localparam logic [7:0] CMD_LOCK_WAVE    = 8'h05;
    localparam logic [7:0] CMD_MUX_SEL      = 8'h06;
    localparam logic [7:0] CMD_MASK_ENABLE  = 8'h07;
    localparam logic [7:0] CMD_ADC_RUN      = 8'h08;
    localparam logic [7:0] CMD_ADC_SHIFT    = 8'h09;
    localparam logic [7:0] CMD_FLUSH        = 8'h0A;
    localparam logic [7:0] CMD_DAC_WORD     = 8'h0B;
    localparam logic [7:0] CMD_ADC_FETCH    = 8'h0C;
    localparam logic [7:0] CMD_CLOCK_STATUS = 8'h0D;
    localparam logic [7:0] CMD_ADC_DUMMY    = 8'h0E;
    localparam logic [7:0] CMD_ADC_READOUT  = 8'h0F;
    localparam logic [7:0] CMD_PING         = 8'h10;

    // Setting targets that differ from the command code
    localparam logic [3:0] TGT_ADC_DUMMY   = 4'd2;
    localparam logic [3:0] TGT_ADC_READOUT = 4'd5;
    localparam logic [3:0] TGT_MASK_TABLE  = 4'd10;
    localparam logic [3:0] TGT_LOCK_WAVE   = 4'd11;

    // Payload lengths in bytes
    localparam int unsigned STORE_BYTES = 32;
    localparam logic [5:0] LEN_NONE  = 6'd0;
    localparam logic [5:0] LEN_BYTE  = 6'd1;
    localparam logic [5:0] LEN_WORD  = 6'd4;
    localparam logic [5:0] LEN_LONG  = 6'd8;
    localparam logic [5:0] LEN_TABLE = 6'd32;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_TX      = 3'd0,
        KIND_SETTING = 3'd1,
        KIND_SAMPLE  = 3'd2,
        KIND_DAC     = 3'd3,
        KIND_FLUSH   = 3'd4
    } kind_t;

    // Work handed from the front to the back
    typedef enum logic [2:0] {
        OP_FLUSH   = 3'd0,
        OP_TX      = 3'd1,
        OP_ADC     = 3'd2,
        OP_SETTING = 3'd3,
        OP_DAC     = 3'd4,
        OP_TABLE   = 3'd5
    } job_op_t;

    typedef struct packed {
        job_op_t                    op;
        logic [3:0]                 target;
        logic [7:0]                 status;
        logic [STORE_BYTES*8-1:0]   data;
    } job_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sfd_if.sv =====
// Valid/ready channel interfaces for the serial command frame decoder.
// No dependencies.
`default_nettype none

interface sfd_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  rx_byte;
    logic        dac_clock_flag;
    logic        adc_clock_flag;
    logic [31:0] adc_sample_word;
    logic        adc_read_fail;
    logic        dac_write_fail;

    modport source (
        output valid, rx_byte, dac_clock_flag, adc_clock_flag,
               adc_sample_word, adc_read_fail, dac_write_fail,
        input  ready
    );
    modport sink (
        input  valid, rx_byte, dac_clock_flag, adc_clock_flag,
               adc_sample_word, adc_read_fail, dac_write_fail,
        output ready
    );
endinterface

interface sfd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  tx_data;
    logic [3:0]  target;
    logic [63:0] write_value;
    logic [3:0]  sample_index;
    logic        last;

    modport source (
        output valid, kind, tx_data, target, write_value, sample_index, last,
        input  ready
    );
    modport sink (
        input  valid, kind, tx_data, target, write_value, sample_index, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/sfd_front.sv =====
// Front end: frame parser, payload store and job builder.
// Depends on sfd_pkg and sfd_in_if.
`default_nettype none

module sfd_front (
    input  wire logic        clk,
    input  wire logic        rst_n,
    sfd_in_if.sink           cmd_in,
    input  wire logic        job_full,
    output logic             job_push,
    output sfd_pkg::job_t    job
);
    import sfd_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_CMD     = 3'b010,
        PH_PAYLOAD = 3'b100
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] cmd_reg, cmd_next;
    logic [5:0] left_reg, left_next;
    logic [7:0] store [STORE_BYTES];

    logic                     accept;
    logic [5:0]               cur_len;
    logic [5:0]               new_len;
    logic [4:0]               idx;
    logic [STORE_BYTES*8-1:0] merged;
    logic [7:0]               b;

    function automatic logic [5:0] payload_len(input logic [7:0] code);
        case (code) inside
            CMD_CHANNEL, CMD_MUX_SEL, CMD_MASK_ENABLE, CMD_ADC_DUMMY,
            CMD_ADC_READOUT: return LEN_BYTE;
            CMD_DAC_WORD: return LEN_WORD;
            CMD_RUN_CYCLES, CMD_PRE_DELAY, CMD_POST_DELAY, CMD_ADC_RUN,
            CMD_ADC_SHIFT: return LEN_LONG;
            CMD_MASK_TABLE, CMD_LOCK_WAVE: return LEN_TABLE;
            default: return LEN_NONE;
        endcase
    endfunction

    function automatic logic [3:0] setting_target(input logic [7:0] code);
        if (code == CMD_ADC_DUMMY) begin
            return TGT_ADC_DUMMY;
        end
        if (code == CMD_ADC_READOUT) begin
            return TGT_ADC_READOUT;
        end
        return code[3:0];
    endfunction

    assign cmd_in.ready = !job_full;
    assign accept       = cmd_in.valid && !job_full;
    assign b            = cmd_in.rx_byte;
    assign new_len      = payload_len(b);
    assign cur_len      = payload_len(cmd_reg);
    assign idx          = 5'(cur_len - left_reg);

    // Store contents with the byte of this transfer already in place
    always_comb
    begin
        for (int j = 0; j < STORE_BYTES; j++)
        begin
            merged[j*8 +: 8] = (5'(j) == idx) ? b : store[j];
        end
    end

    // Parse the frame and build the job for the back end
    always_comb
    begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        left_next  = left_reg;
        job_push   = 1'b0;
        job        = '0;
        job.op     = OP_TX;
        job.status = ACK_BYTE;
        if (accept)
        begin
            case (phase_reg)
                PH_CMD:
                begin
                    cmd_next   = b;
                    phase_next = PH_IDLE;
                    if (new_len != LEN_NONE)
                    begin
                        left_next  = new_len;
                        phase_next = PH_PAYLOAD;
                    end
                    else
                    begin
                        case (b)
                            CMD_FLUSH:
                            begin
                                job_push = 1'b1;
                                job.op   = OP_FLUSH;
                            end
                            CMD_CLOCK_STATUS:
                            begin
                                job_push   = 1'b1;
                                job.status = {6'b0, cmd_in.adc_clock_flag,
                                              cmd_in.dac_clock_flag};
                            end
                            CMD_ADC_FETCH:
                            begin
                                job_push = 1'b1;
                                job.op   = OP_ADC;
                                if (cmd_in.adc_read_fail)
                                begin
                                    job.status = ERR_BYTE;
                                end
                                else
                                begin
                                    job.data[31:0] = cmd_in.adc_sample_word;
                                end
                            end
                            CMD_PING:
                            begin
                                job_push = 1'b1;
                            end
                            default:
                            begin
                                job_push = 1'b0;
                            end
                        endcase
                    end
                end
                PH_PAYLOAD:
                begin
                    left_next = left_reg - 6'd1;
                    if (left_next == 6'd0)
                    begin
                        phase_next = PH_IDLE;
                        job_push   = 1'b1;
                        case (cur_len)
                            LEN_BYTE:
                            begin
                                job.op        = OP_SETTING;
                                job.target    = setting_target(cmd_reg);
                                job.data[7:0] = merged[7:0];
                            end
                            LEN_LONG:
                            begin
                                job.op         = OP_SETTING;
                                job.target     = setting_target(cmd_reg);
                                job.data[63:0] = merged[63:0];
                            end
                            LEN_WORD:
                            begin
                                job.op         = OP_DAC;
                                job.data[31:0] = merged[31:0];
                                if (cmd_in.dac_write_fail)
                                begin
                                    job.status = ERR_BYTE;
                                end
                            end
                            LEN_TABLE:
                            begin
                                job.op     = OP_TABLE;
                                job.target = (cmd_reg == CMD_MASK_TABLE) ?
                                             TGT_MASK_TABLE : TGT_LOCK_WAVE;
                                job.data   = merged;
                            end
                            default:
                            begin
                                job.op = OP_TX;
                            end
                        endcase
                    end
                end
                default:
                begin
                    phase_next = (b == PREAMBLE) ? PH_CMD : PH_IDLE;
                end
            endcase
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cmd_reg   <= '0;
            left_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            left_reg  <= left_next;
        end
    end

    // Write payload bytes into the store
    always_ff @(posedge clk)
    begin
        if (accept && (phase_reg == PH_PAYLOAD))
        begin
            store[idx] <= b;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sfd_job_fifo.sv =====
// Short job queue between the front and back ends.
// Depends on sfd_pkg.
`default_nettype none

module sfd_job_fifo #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire sfd_pkg::job_t   push_job,
    output logic                 full,
    input  wire logic            pop,
    output sfd_pkg::job_t        pop_job,
    output logic                 not_empty
);
    import sfd_pkg::*;

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    job_t            slots [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign full      = (count_reg == FullCnt);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_job   = slots[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write job slots
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sfd_back.sv =====
// Back end: expands one job into its result transfers, one per cycle while the receiver takes them.
// Depends on sfd_pkg and sfd_out_if.
`default_nettype none

module sfd_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire sfd_pkg::job_t   job,
    input  wire logic            job_valid,
    output logic                 job_pop,
    sfd_out_if.source            res_out
);
    import sfd_pkg::*;

    logic [4:0]  step_reg, step_next;
    logic [4:0]  final_step;
    logic        is_final;
    logic        load;
    logic        valid_reg, valid_next;
    kind_t       kind_reg, kind_next;
    logic [7:0]  tx_reg, tx_next;
    logic [3:0]  target_reg, target_next;
    logic [63:0] value_reg, value_next;
    logic [3:0]  index_reg, index_next;
    logic        last_reg, last_next;

    // Step of the closing status byte for each job
    always_comb
    begin
        case (job.op)
            OP_FLUSH:   final_step = 5'd1;
            OP_ADC:     final_step = 5'd4;
            OP_SETTING: final_step = 5'd1;
            OP_DAC:     final_step = 5'd1;
            OP_TABLE:   final_step = 5'd16;
            default:    final_step = 5'd0;
        endcase
    end

    assign is_final = (step_reg == final_step);
    assign load     = job_valid && (!valid_reg || res_out.ready);
    assign job_pop  = load && is_final;

    // Build the next result
    always_comb
    begin
        kind_next   = KIND_TX;
        tx_next     = '0;
        target_next = '0;
        value_next  = '0;
        index_next  = '0;
        last_next   = 1'b0;
        if (is_final)
        begin
            tx_next   = job.status;
            last_next = 1'b1;
        end
        else
        begin
            case (job.op)
                OP_FLUSH:
                begin
                    kind_next = KIND_FLUSH;
                end
                OP_ADC:
                begin
                    tx_next = job.data[{step_reg[1:0], 3'b000} +: 8];
                end
                OP_SETTING:
                begin
                    kind_next   = KIND_SETTING;
                    target_next = job.target;
                    value_next  = job.data[63:0];
                end
                OP_DAC:
                begin
                    kind_next  = KIND_DAC;
                    value_next = job.data[63:0];
                end
                OP_TABLE:
                begin
                    kind_next   = KIND_SAMPLE;
                    target_next = job.target;
                    value_next  = {48'b0, job.data[{step_reg[3:0], 4'b0000} +: 16]};
                    index_next  = step_reg[3:0];
                end
                default:
                begin
                    kind_next = KIND_TX;
                end
            endcase
        end
    end

    // Advance the step and the output valid
    always_comb
    begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (load)
        begin
            step_next  = is_final ? '0 : step_reg + 5'd1;
            valid_next = 1'b1;
        end
        else if (res_out.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    // Hold the result payload until it is taken
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg   <= kind_next;
            tx_reg     <= tx_next;
            target_reg <= target_next;
            value_reg  <= value_next;
            index_reg  <= index_next;
            last_reg   <= last_next;
        end
    end

    assign res_out.valid        = valid_reg;
    assign res_out.kind         = kind_reg;
    assign res_out.tx_data      = tx_reg;
    assign res_out.target       = target_reg;
    assign res_out.write_value  = value_reg;
    assign res_out.sample_index = index_reg;
    assign res_out.last         = last_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/serial_command_frame_decoder_unit.sv =====
// Serial command frame decoder: one received byte per input transfer.
// Takes a byte every cycle while the job queue has room; each result passes
// through the job queue and the output register, then one result per cycle
// while the receiver takes them (up to seventeen after the last table byte).
// Reset clears the frame state, job queue and output register; the payload
// store is not cleared and needs no clearing pass.
`default_nettype none

module serial_command_frame_decoder_unit #(
    parameter int unsigned JOB_FIFO_DEPTH = 2
) (
    input  wire logic clk,
    input  wire logic rst_n,
    sfd_in_if.sink    cmd_in,
    sfd_out_if.source res_out
);
    import sfd_pkg::*;

    job_t push_job;
    job_t pop_job;
    logic job_push;
    logic job_full;
    logic job_pop;
    logic job_valid;

    // Parse frames
    sfd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_in   (cmd_in),
        .job_full (job_full),
        .job_push (job_push),
        .job      (push_job)
    );

    // Queue jobs
    sfd_job_fifo #(
        .DEPTH (JOB_FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_job  (push_job),
        .full      (job_full),
        .pop       (job_pop),
        .pop_job   (pop_job),
        .not_empty (job_valid)
    );

    // Emit results
    sfd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (pop_job),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .res_out   (res_out)
    );

endmodule

`default_nettype wire

// ===== test/serial_command_frame_decoder_unit_test.sv =====
// Self-checking testbench for serial_command_frame_decoder_unit.
// Depends on sfd_pkg (codes, kinds) and the sfd_in_if / sfd_out_if channel interfaces.
// A table of directed bytes comes first, then random frames, checked against typed table rows or a frame decoder.
module serial_command_frame_decoder_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sfd_pkg::*;

    localparam int unsigned RANDOM_ITEMS    = 455;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES    = 40;
    localparam int unsigned DIRECTED_COUNT  = 25;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_COMMAND = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_SPARE   = 2'd3
    } frame_phase_t;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic        dac_clock_flag;
        logic        adc_clock_flag;
        logic [31:0] adc_sample_word;
        logic        adc_read_fail;
        logic        dac_write_fail;
    } rx_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  tx_data;
        logic [3:0]  target;
        logic [63:0] write_value;
        logic [3:0]  sample_index;
        logic        last;
    } result_t;

    typedef struct packed {
        rx_item_t stim;
        logic     typed;
        result_t  want;
    } row_t;

    localparam result_t NOT_TYPED  = '{KIND_TX, 8'h00, 4'h0, 64'h0, 4'h0, 1'b0};
    localparam result_t ACK_ONLY   = '{KIND_TX, ACK_BYTE, 4'h0, 64'h0, 4'h0, 1'b1};
    localparam result_t CLOCKS_DAC = '{KIND_TX, 8'h01, 4'h0, 64'h0, 4'h0, 1'b1};
    localparam result_t CLOCKS_ADC = '{KIND_TX, 8'h02, 4'h0, 64'h0, 4'h0, 1'b1};

    // Directed bytes: drops, frames of each answer-at-once kind, an unknown
    // command, a one-byte setting and a DAC word whose write fails.
    localparam row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{'{8'h00,            1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, NOT_TYPED},
        '{'{8'hFF,            1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1}, 1'b0, NOT_TYPED},
        '{'{PREAMBLE,         1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, NOT_TYPED},
        '{'{CMD_PING,         1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b0}, 1'b1, ACK_ONLY},
        '{'{PREAMBLE,         1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, NOT_TYPED},
        '{'{CMD_CLOCK_STATUS, 1'b1, 1'b0, 32'h0000_0000, 1'b0, 1'b0}, 1'b1, CLOCKS_DAC},
        '{'{PREAMBLE,         1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, NOT_TYPED},
        '{'{CMD_CLOCK_STATUS, 1'b0, 1'b1, 32'h0000_0000, 1'b0, 1'b0}, 1'b1, CLOCKS_ADC},
        '{'{PREAMBLE,         1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, NOT_TYPED},
        '{'{CMD_FLUSH,        1'b1, 1'b1, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, NOT_TYPED},
        '{'{PREAMBLE,         1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, NOT_TYPED},
        '{'{CMD_ADC_FETCH,    1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0}, 1'b0, NOT_TYPED},
        '{'{PREAMBLE,         1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, NOT_TYPED},
        '{'{CMD_ADC_FETCH,    1'b0, 1'b0, 32'h1234_5678, 1'b1, 1'b0}, 1'b0, NOT_TYPED},
        '{'{PREAMBLE,         1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, NOT_TYPED},
        '{'{8'hFF,            1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, NOT_TYPED},
        '{'{PREAMBLE,         1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, NOT_TYPED},
        '{'{CMD_ADC_READOUT,  1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, NOT_TYPED},
        '{'{8'hFF,            1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, NOT_TYPED},
        '{'{PREAMBLE,         1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, NOT_TYPED},
        '{'{CMD_DAC_WORD,     1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, NOT_TYPED},
        '{'{8'h00,            1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, NOT_TYPED},
        '{'{8'hFF,            1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, NOT_TYPED},
        '{'{8'h80,            1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, NOT_TYPED},
        '{'{8'h7F,            1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b1}, 1'b0, NOT_TYPED}
    };

    localparam logic [7:0] KNOWN_CODES [17] = '{
        CMD_CHANNEL, CMD_RUN_CYCLES, CMD_MASK_TABLE, CMD_PRE_DELAY, CMD_POST_DELAY,
        CMD_LOCK_WAVE, CMD_MUX_SEL, CMD_MASK_ENABLE, CMD_ADC_RUN, CMD_ADC_SHIFT,
        CMD_FLUSH, CMD_DAC_WORD, CMD_ADC_FETCH, CMD_CLOCK_STATUS, CMD_ADC_DUMMY,
        CMD_ADC_READOUT, CMD_PING
    };

    logic clk;
    logic rst_n;

    sfd_in_if  cmd_ch ();
    sfd_out_if res_ch ();

    serial_command_frame_decoder_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd_in  (cmd_ch),
        .res_out (res_ch)
    );

    // Decoder state mirrored on the test side
    frame_phase_t dec_phase;
    logic [7:0]   dec_cmd;
    logic [5:0]   dec_left;
    logic [7:0]   payload_bytes [STORE_BYTES];

    result_t     byte_results [$];
    result_t     awaited_results [$];
    int unsigned mismatches;
    logic        sink_hold_req;

    // Clock and reset
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    initial
    begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Guard against a hung run
    initial
    begin
        #50ms;
        $display("[serial_command_frame_decoder_unit] ERROR");
        $finish;
    end

    // Gap length for either side: mostly none, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic logic [5:0] payload_len(input logic [7:0] code);
        case (code)
            CMD_CHANNEL, CMD_MUX_SEL, CMD_MASK_ENABLE, CMD_ADC_DUMMY, CMD_ADC_READOUT:
                return LEN_BYTE;
            CMD_DAC_WORD:
                return LEN_WORD;
            CMD_RUN_CYCLES, CMD_PRE_DELAY, CMD_POST_DELAY, CMD_ADC_RUN, CMD_ADC_SHIFT:
                return LEN_LONG;
            CMD_MASK_TABLE, CMD_LOCK_WAVE:
                return LEN_TABLE;
            default:
                return LEN_NONE;
        endcase
    endfunction

    function automatic logic [3:0] setting_target(input logic [7:0] code);
        if (code == CMD_ADC_DUMMY)
            return TGT_ADC_DUMMY;
        else if (code == CMD_ADC_READOUT)
            return TGT_ADC_READOUT;
        else
            return code[3:0];
    endfunction

    // Little-endian word from the first n payload bytes, at most eight
    function automatic logic [63:0] gather_word(input logic [5:0] n);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < 8; i++)
            if (i < n)
                v[8*i +: 8] = payload_bytes[i];
        return v;
    endfunction

    function automatic void emit(input kind_t k, input logic [7:0] tx,
                                 input logic [3:0] tgt, input logic [63:0] val,
                                 input logic [3:0] sidx);
        result_t r;
        r = '{k, tx, tgt, val, sidx, 1'b0};
        byte_results.push_back(r);
    endfunction

    // Advance the decoder by one received byte and list the results it causes
    task automatic decode_byte(input rx_item_t it);
        logic [5:0]  len;
        logic [5:0]  slot;
        logic [7:0]  status;
        logic [31:0] word;
        logic [3:0]  tgt;
        result_t     r;
        byte_results.delete();
        case (dec_phase)
            PH_COMMAND:
            begin
                dec_cmd   = it.rx_byte;
                len       = payload_len(it.rx_byte);
                dec_phase = PH_IDLE;
                if (len != LEN_NONE)
                begin
                    dec_left  = len;
                    dec_phase = PH_PAYLOAD;
                end
                else if (it.rx_byte == CMD_FLUSH)
                begin
                    emit(KIND_FLUSH, 8'h00, 4'h0, 64'h0, 4'h0);
                    emit(KIND_TX, ACK_BYTE, 4'h0, 64'h0, 4'h0);
                end
                else if (it.rx_byte == CMD_CLOCK_STATUS)
                begin
                    emit(KIND_TX, {6'b0, it.adc_clock_flag, it.dac_clock_flag},
                         4'h0, 64'h0, 4'h0);
                end
                else if (it.rx_byte == CMD_ADC_FETCH)
                begin
                    word = it.adc_read_fail ? 32'h0 : it.adc_sample_word;
                    for (int i = 0; i < 4; i++)
                        emit(KIND_TX, word[8*i +: 8], 4'h0, 64'h0, 4'h0);
                    emit(KIND_TX, it.adc_read_fail ? ERR_BYTE : ACK_BYTE, 4'h0, 64'h0, 4'h0);
                end
                else if (it.rx_byte == CMD_PING)
                begin
                    emit(KIND_TX, ACK_BYTE, 4'h0, 64'h0, 4'h0);
                end
            end
            PH_PAYLOAD:
            begin
                len      = payload_len(dec_cmd);
                slot     = len - dec_left;
                status   = ACK_BYTE;
                payload_bytes[slot[4:0]] = it.rx_byte;
                dec_left = dec_left - 6'd1;
                if (dec_left == 6'd0)
                begin
                    case (len)
                        LEN_BYTE, LEN_LONG:
                            emit(KIND_SETTING, 8'h00, setting_target(dec_cmd),
                                 gather_word(len), 4'h0);
                        LEN_WORD:
                        begin
                            emit(KIND_DAC, 8'h00, 4'h0, gather_word(len), 4'h0);
                            if (it.dac_write_fail)
                                status = ERR_BYTE;
                        end
                        LEN_TABLE:
                        begin
                            tgt = (dec_cmd == CMD_MASK_TABLE) ? TGT_MASK_TABLE : TGT_LOCK_WAVE;
                            for (int i = 0; i < 16; i++)
                                emit(KIND_SAMPLE, 8'h00, tgt,
                                     {48'h0, payload_bytes[2*i+1], payload_bytes[2*i]},
                                     4'(i));
                        end
                        default:
                        begin
                        end
                    endcase
                    emit(KIND_TX, status, 4'h0, 64'h0, 4'h0);
                    dec_phase = PH_IDLE;
                end
            end
            default:
                dec_phase = (it.rx_byte == PREAMBLE) ? PH_COMMAND : PH_IDLE;
        endcase
        // Flag the final result of this byte
        if (byte_results.size() != 0)
        begin
            r = byte_results.pop_back();
            r.last = 1'b1;
            byte_results.push_back(r);
        end
    endtask

    function automatic rx_item_t random_item(input logic [7:0] b);
        rx_item_t it;
        int unsigned r;
        it.rx_byte        = b;
        it.dac_clock_flag = 1'($urandom_range(0, 1));
        it.adc_clock_flag = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 7);
        if (r == 0)
            it.adc_sample_word = 32'h0;
        else if (r == 1)
            it.adc_sample_word = 32'hFFFF_FFFF;
        else
            it.adc_sample_word = $urandom;
        it.adc_read_fail  = ($urandom_range(0, 3) == 0);
        it.dac_write_fail = ($urandom_range(0, 3) == 0);
        return it;
    endfunction

    // Offer one byte after a random gap, hold it until the transfer, then
    // queue what it should cause
    task automatic send_byte(input rx_item_t it, input logic typed, input result_t want);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid           <= 1'b1;
        cmd_ch.rx_byte         <= it.rx_byte;
        cmd_ch.dac_clock_flag  <= it.dac_clock_flag;
        cmd_ch.adc_clock_flag  <= it.adc_clock_flag;
        cmd_ch.adc_sample_word <= it.adc_sample_word;
        cmd_ch.adc_read_fail   <= it.adc_read_fail;
        cmd_ch.dac_write_fail  <= it.dac_write_fail;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        decode_byte(it);
        if (typed)
            awaited_results.push_back(want);
        else
            foreach (byte_results[i])
                awaited_results.push_back(byte_results[i]);
    endtask

    // Stimulus
    initial
    begin
        int unsigned frame_items;
        int unsigned pick;
        logic [7:0]  code;
        logic [5:0]  len;
        logic        held_off;
        logic        drained;

        cmd_ch.valid           = 1'b0;
        cmd_ch.rx_byte         = 8'h00;
        cmd_ch.dac_clock_flag  = 1'b0;
        cmd_ch.adc_clock_flag  = 1'b0;
        cmd_ch.adc_sample_word = 32'h0;
        cmd_ch.adc_read_fail   = 1'b0;
        cmd_ch.dac_write_fail  = 1'b0;
        dec_phase     = PH_IDLE;
        dec_cmd       = 8'h00;
        dec_left      = 6'd0;
        sink_hold_req = 1'b0;
        mismatches    = 0;
        frame_items   = 0;
        held_off      = 1'b0;
        drained       = 1'b0;
        foreach (payload_bytes[i])
            payload_bytes[i] = 8'h00;

        wait (rst_n === 1'b1);
        @(posedge clk);

        // Walk the directed table
        for (int i = 0; i < DIRECTED_COUNT; i++)
            send_byte(DIRECTED_ROWS[i].stim, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

        // Random frames, some noise and some broken frames
        while (frame_items < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                code = 8'($urandom_range(0, 255));
                if (code == PREAMBLE)
                    code = 8'h55;
                send_byte(random_item(code), 1'b0, NOT_TYPED);
                frame_items += 1;
            end
            else if (pick < 16)
            begin
                do
                    code = 8'($urandom_range(0, 255));
                while (payload_len(code) != LEN_NONE || code == CMD_FLUSH ||
                       code == CMD_ADC_FETCH || code == CMD_CLOCK_STATUS ||
                       code == CMD_PING);
                send_byte(random_item(PREAMBLE), 1'b0, NOT_TYPED);
                send_byte(random_item(code), 1'b0, NOT_TYPED);
                frame_items += 2;
            end
            else
            begin
                code = KNOWN_CODES[$urandom_range(0, 16)];
                len  = payload_len(code);
                send_byte(random_item(PREAMBLE), 1'b0, NOT_TYPED);
                send_byte(random_item(code), 1'b0, NOT_TYPED);
                for (int i = 0; i < len; i++)
                    send_byte(random_item(8'($urandom_range(0, 255))), 1'b0, NOT_TYPED);
                frame_items += 2 + len;
            end

            // Hold the receiver off for a long stretch once, keep sending
            if (!held_off && frame_items >= 120)
            begin
                held_off      = 1'b1;
                sink_hold_req = 1'b1;
            end

            // Pause once until every awaited result has come
            if (!drained && frame_items >= 300)
            begin
                drained = 1'b1;
                cmd_ch.valid <= 1'b0;
                wait (awaited_results.size() == 0);
                @(posedge clk);
            end
        end

        cmd_ch.valid <= 1'b0;
        wait (awaited_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("[serial_command_frame_decoder_unit] OK");
        else
            $display("[serial_command_frame_decoder_unit] ERROR");
        $finish;
    end

    // Result side ready: random gaps, plus one long hold-off on request
    initial
    begin
        int unsigned idle_cycles;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (sink_hold_req)
            begin
                sink_hold_req = 1'b0;
                idle_cycles   = HOLD_OFF_CYCLES;
            end
            else
                idle_cycles = pick_gap();
            if (idle_cycles == 0)
                res_ch.ready <= 1'b1;
            else
            begin
                res_ch.ready <= 1'b0;
                repeat (idle_cycles) @(posedge clk);
                res_ch.ready <= 1'b1;
            end
        end
    end

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Check each result transfer against the oldest awaited result
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got kind %h value %h",
                         $time, res_ch.kind, res_ch.write_value);
                mismatches++;
            end
            else
            begin
                want = awaited_results.pop_front();
                compare_field("kind", 64'(want.kind), 64'(res_ch.kind));
                compare_field("tx_data", 64'(want.tx_data), 64'(res_ch.tx_data));
                compare_field("target", 64'(want.target), 64'(res_ch.target));
                compare_field("write_value", want.write_value, res_ch.write_value);
                compare_field("sample_index", 64'(want.sample_index), 64'(res_ch.sample_index));
                compare_field("last", 64'(want.last), 64'(res_ch.last));
            end
        end
    end

endmodule
